// ===== rtl/core/bol_pkg.sv =====
// Shared constants, request/status codes and cell control type for the ordered list.
package bol_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IdxW   = $clog2(DEPTH);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 10;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned StatW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_BACK  = 3'd1,
    REQ_ADD_AT    = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_BACK  = 3'd4,
    REQ_REM_AT    = 3'd5
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    cell_op_e               op;
    logic [IdxW-1:0]        pos;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

endpackage

// ===== rtl/core/bounded_ordered_list.sv =====
// Top level of the bounded ordered list: request decode, cell row and result register.
module bounded_ordered_list import bol_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic [CntW-1:0]         count_o,
  output logic signed [DataW-1:0] front_value_o,
  output logic signed [DataW-1:0] back_value_o
);

  // A list of up to DEPTH signed words kept in a row of cells. Each
  // transaction inserts at the front, the back or an index (0..count), or
  // removes from the front, the back or an index below count. Every cell
  // compares its own index with the target and, in the same cycle, holds,
  // takes its left neighbour (insert), takes its right neighbour (remove) or
  // loads the new word, so a whole request is applied in a single row update and
  // one transaction per cycle is sustained while the input is not stalled. The
  // result (status, count, front and back after the request) passes the cell
  // row and then the result register that reads the front cell and the cell at
  // count-1. A stalled result register holds, and the input stalls only while
  // an updated request is still waiting behind it.
  // Status order: a bad index is reported before a full list.

  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic pend_d, pend_q;
  logic out_valid_d, out_valid_q;
  logic acc, out_load;

  assign in_stall_o = pend_q && out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign out_load   = pend_q && !(out_valid_q && out_stall_i);

  // ---------------------------------------------------------------------
  // Request decode against the current count
  // ---------------------------------------------------------------------
  logic [CntW-1:0]  count_d, count_q;
  status_e          status_d, status_q;
  cell_ctl_t        ctl;
  logic             full, empty;
  logic [PosW:0]    pos_ext, cnt_ext;

  assign full    = (count_q >= FullCnt);
  assign empty   = (count_q == '0);
  assign pos_ext = {1'b0, position_i};
  assign cnt_ext = (PosW + 1)'(count_q);

  always_comb begin
    status_d  = ST_OK;
    ctl.op    = OP_HOLD;
    ctl.pos   = '0;
    ctl.value = value_i;
    case (req_e'(req_type_i))
      REQ_ADD_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op = OP_INSERT;
        end
      end
      REQ_ADD_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op  = OP_INSERT;
          ctl.pos = IdxW'(count_q);
        end
      end
      REQ_ADD_AT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.op  = OP_INSERT;
          ctl.pos = IdxW'(position_i);
        end
      end
      REQ_REM_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.op = OP_REMOVE;
        end
      end
      REQ_REM_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.op  = OP_REMOVE;
          ctl.pos = IdxW'(count_q - 1'b1);
        end
      end
      REQ_REM_AT: begin
        if (empty && (position_i == '0)) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          ctl.op  = OP_REMOVE;
          ctl.pos = IdxW'(position_i);
        end
      end
      default: begin
        status_d = ST_OK;  // unused codes: no change
      end
    endcase
    if (!acc) begin
      ctl.op = OP_HOLD;
    end
  end

  always_comb begin
    count_d = count_q;
    case (ctl.op)
      OP_INSERT: count_d = count_q + 1'b1;
      OP_REMOVE: count_d = count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  // ---------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------
  logic signed [DataW-1:0] cell_data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = value_i;  // never taken: cell 0 is never right of the target
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];  // beyond count after a remove
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    bol_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IdxW'(g)),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  // Back cell select: count-1, meaningful only when not empty
  logic [IdxW-1:0]         back_idx;
  logic signed [DataW-1:0] back_sel;

  assign back_idx = IdxW'(count_q - 1'b1);
  assign back_sel = cell_data[back_idx];

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_comb begin
    pend_d = pend_q;
    if (acc) begin
      pend_d = 1'b1;
    end else if (out_load) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
    end
  end

  // Result register: samples the updated row when the pending result can load
  logic [StatW-1:0]        status_out_q;
  logic [CntW-1:0]         count_out_q;
  logic signed [DataW-1:0] front_out_q, back_out_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_out_q <= status_q;
      count_out_q  <= count_q;
      front_out_q  <= empty ? '0 : cell_data[0];
      back_out_q   <= empty ? '0 : back_sel;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign count_o       = count_out_q;
  assign front_value_o = front_out_q;
  assign back_value_o  = back_out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("list count beyond depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (count_o == FullCnt))
    else $error("full status with list not full");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY))
      |-> ((count_o == '0) && (front_value_o == '0) && (back_value_o == '0)))
    else $error("empty status with non-empty result");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && full && (req_type_i == REQ_ADD_FRONT)) |=> (count_q == $past(count_q)))
    else $error("count changed on add to full list");
`endif

endmodule

// ===== rtl/core/bol_cell.sv =====
// One storage cell of the list: holds, takes its left or right neighbour, or loads a new value.
module bol_cell import bol_pkg::*; (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic [IdxW-1:0]         idx_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  output logic signed [DataW-1:0] data_o
);

  logic signed [DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (idx_i > ctl_i.pos) begin
          data_d = left_i;
        end else if (idx_i == ctl_i.pos) begin
          data_d = ctl_i.value;
        end
      end
      OP_REMOVE: begin
        if (idx_i >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== tb/tb_bounded_ordered_list.sv =====
// Self-checking testbench for the bounded ordered list: directed and random requests.
module tb_bounded_ordered_list import bol_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD   = 10ns;
  localparam int unsigned RESET_CYCLES = 7;
  // Cycles with no transaction on either side before the run is declared hung.
  // A result stall run at 71 % of that length is far beyond any real chance.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Result register sits behind the cell row register that takes the request.
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 660;

  // Request codes 6 and 7 have no meaning; the list must ignore them.
  localparam logic [ReqW-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [DataW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [PosW-1:0]         POS_TOP = '1;

  typedef struct {
    status_e                 status;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] front;
    logic signed [DataW-1:0] back;
  } list_result_t;

  // Shadow copy of the list plus the queue of results it predicts.
  class ordered_list_shadow;
    logic signed [DataW-1:0] contents[$];
    list_result_t            expected_results[$];
    int unsigned             mismatches;
    int unsigned             results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(logic [ReqW-1:0] kind, logic [PosW-1:0] pos,
                               logic signed [DataW-1:0] val);
      list_result_t exp;
      int           cnt;
      int           p;
      cnt        = contents.size();
      p          = pos;
      exp.status = ST_OK;
      case (kind)
        REQ_ADD_FRONT: begin
          if (cnt >= DEPTH) exp.status = ST_FULL;
          else contents.push_front(val);
        end
        REQ_ADD_BACK: begin
          if (cnt >= DEPTH) exp.status = ST_FULL;
          else contents.push_back(val);
        end
        REQ_ADD_AT: begin
          // index check wins over the full check
          if (p > cnt) exp.status = ST_RANGE;
          else if (cnt >= DEPTH) exp.status = ST_FULL;
          else contents.insert(p, val);
        end
        REQ_REM_FRONT: begin
          if (cnt == 0) exp.status = ST_EMPTY;
          else contents.delete(0);
        end
        REQ_REM_BACK: begin
          if (cnt == 0) exp.status = ST_EMPTY;
          else contents.delete(cnt - 1);
        end
        REQ_REM_AT: begin
          if (cnt == 0 && p == 0) exp.status = ST_EMPTY;
          else if (p >= cnt) exp.status = ST_RANGE;
          else contents.delete(p);
        end
        default: ;
      endcase
      exp.count = CntW'(contents.size());
      if (contents.size() == 0) begin
        exp.front = '0;
        exp.back  = '0;
      end else begin
        exp.front = contents[0];
        exp.back  = contents[contents.size() - 1];
      end
      expected_results.push_back(exp);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [StatW-1:0] status, logic [CntW-1:0] count,
                               logic signed [DataW-1:0] front,
                               logic signed [DataW-1:0] back);
      list_result_t exp;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with none outstanding: status %0d count %0d",
                   results_seen, status, count);
        return;
      end
      exp = expected_results.pop_front();
      if (status !== exp.status || count !== exp.count ||
          front !== exp.front || back !== exp.back) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d mismatch: expected status %0d count %0d ", results_seen,
                   exp.status, exp.count,
                   "front %0d back %0d, ", exp.front, exp.back,
                   "got status %0d count %0d front %0d back %0d",
                   status, count, front, back);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [ReqW-1:0]         req_type_i    = '0;
  logic [PosW-1:0]         position_i    = '0;
  logic signed [DataW-1:0] value_i       = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic [StatW-1:0]        status_o;
  logic [CntW-1:0]         count_o;
  logic signed [DataW-1:0] front_value_o;
  logic signed [DataW-1:0] back_value_o;

  ordered_list_shadow list_shadow;

  // Idle rates in percent, changed by the stimulus between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  bounded_ordered_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .count_o       (count_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Result side back-pressure: a fresh coin every cycle at the current rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Both monitors in one block: the request is noted before any result is
  // checked, so a same-edge result always finds its prediction queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        list_shadow.note_request(req_type_i, position_i, value_i);
      if (out_valid_o && !out_stall_i)
        list_shadow.check_result(status_o, count_o, front_value_o, back_value_o);
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one request and hold it until the list takes it. Valid stays high
  // on return; the next call either keeps it up or drops it for a gap.
  task automatic send_request(logic [ReqW-1:0] kind, logic [PosW-1:0] pos,
                              logic signed [DataW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (list_shadow.pending() != 0) @(posedge clk_i);
  endtask

  // Random requests in stretches that lean towards filling, emptying or
  // churning the list, so full and empty are both hit again and again.
  task automatic run_random(int unsigned n);
    int unsigned     add_pct;
    int unsigned     r;
    int unsigned     cur;
    logic [ReqW-1:0] kind;
    logic [PosW-1:0] pos;
    logic [DataW-1:0] val;
    add_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0:       add_pct = 88;
          1:       add_pct = 12;
          default: add_pct = 50;
        endcase
      end
      cur = list_shadow.contents.size();
      r   = $urandom_range(99);
      if (r < 3) begin
        kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
      end else if ($urandom_range(99) < add_pct) begin
        case ($urandom_range(2))
          0:       kind = REQ_ADD_FRONT;
          1:       kind = REQ_ADD_BACK;
          default: kind = REQ_ADD_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       kind = REQ_REM_FRONT;
          1:       kind = REQ_REM_BACK;
          default: kind = REQ_REM_AT;
        endcase
      end
      // mostly legal indices, some just past the end, some anywhere
      r = $urandom_range(99);
      if (r < 70)      pos = PosW'($urandom_range(cur));
      else if (r < 85) pos = PosW'(cur + $urandom_range(2));
      else             pos = PosW'($urandom_range(POS_TOP));
      r = $urandom_range(99);
      if (r < 4)      val = VAL_MAX;
      else if (r < 8) val = VAL_MIN;
      else if (r < 10) val = '0;
      else            val = $urandom;
      send_request(kind, pos, val);
    end
  endtask

  initial begin
    list_shadow = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 34;
    recv_stall_pct = 71;

    // Directed: removals and bad indices on an empty list, spare codes.
    send_request(REQ_REM_FRONT, '0, '0);
    send_request(REQ_REM_BACK, '0, '0);
    send_request(REQ_REM_AT, '0, '0);
    send_request(REQ_REM_AT, POS_TOP, '0);
    send_request(REQ_ADD_AT, 10'd1, 32'sd5);
    send_request(REQ_SPARE_LO, '0, VAL_MAX);
    send_request(REQ_SPARE_HI, POS_TOP, VAL_MIN);
    // Extreme values, a remove past the end, a remove of the last entry by index.
    send_request(REQ_ADD_AT, '0, VAL_MAX);
    send_request(REQ_ADD_FRONT, '0, VAL_MIN);
    send_request(REQ_REM_AT, 10'd2, '0);
    send_request(REQ_REM_AT, 10'd1, '0);
    // Fill to the top through every kind of add.
    for (int unsigned k = 1; k < DEPTH; k++) begin
      case (k % 3)
        0:       send_request(REQ_ADD_BACK, '0, -32'sd1);
        1:       send_request(REQ_ADD_FRONT, '0, $urandom);
        default: send_request(REQ_ADD_AT, PosW'(k / 2), $urandom);
      endcase
    end
    // Full list: every add refused, a bad index still reported as such.
    send_request(REQ_ADD_FRONT, '0, 32'sd1);
    send_request(REQ_ADD_BACK, '0, 32'sd2);
    send_request(REQ_ADD_AT, PosW'(DEPTH), 32'sd3);
    send_request(REQ_ADD_AT, PosW'(DEPTH + 1), 32'sd4);
    send_request(REQ_ADD_AT, POS_TOP, 32'sd5);

    run_random(PHASE_ITEMS);
    // Hold off the sender until the list has answered everything.
    drain_results();

    send_idle_pct  = 71;
    recv_stall_pct = 34;
    run_random(PHASE_ITEMS);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (list_shadow.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (list_shadow.mismatches == 0 && list_shadow.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bol_pkg.sv
rtl/core/bol_cell.sv
rtl/core/bounded_ordered_list.sv
tb/tb_bounded_ordered_list.sv
